/* rtl/message_fifo_with_truncation_unit_assert.svh */
// assertion macros for the message fifo with truncation unit
`ifndef MESSAGE_FIFO_WITH_TRUNCATION_UNIT_ASSERT_SVH
`define MESSAGE_FIFO_WITH_TRUNCATION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MFIFO_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("mfifo same-cycle check failed");

// next-cycle implication
`define MFIFO_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("mfifo next-cycle check failed");

`else

`define MFIFO_ASSERT_IMPL(label, clk, rst, pre, post)
`define MFIFO_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

/* rtl/mfifo_pkg.sv */
// shared constants, codes and controller/datapath types
package mfifo_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int ELEM_BYTES = 32;

   localparam int SLOT_W    = $clog2(FIFO_DEPTH);
   localparam int COUNT_W   = $clog2(FIFO_DEPTH + 1);
   localparam int BYTE_W    = (ELEM_BYTES > 1) ? $clog2(ELEM_BYTES) : 1;
   localparam int LEN_W     = $clog2(ELEM_BYTES + 1);
   localparam int MEM_DEPTH = FIFO_DEPTH * ELEM_BYTES;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   // fixed field widths
   localparam int CFG_W      = 6;
   localparam int DATA_W     = 8;
   localparam int RCOUNT_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int MSG_LEN_W  = 6;

   localparam logic [CFG_W-1:0] MAX_BYTES_RESET = CFG_W'(32);

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_EMIT  = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic write_byte;
      logic read_empty;
      logic read_none;
      logic read_start;
      logic fetch_next;
      logic emit_byte;
      logic free_slot;
   } dp_cmd_type;

   typedef struct packed {
      logic queue_empty;
      logic read_none;
      logic emit_last;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/mfifo_if.sv */
// request, response and control register channel interfaces
interface mfifo_req_if
   import mfifo_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                op;
   logic [DATA_W-1:0]   data_byte;
   logic                end_of_message;
   logic [RCOUNT_W-1:0] read_count;

   modport source (output valid, op, data_byte, end_of_message, read_count, input ready);
   modport sink   (input valid, op, data_byte, end_of_message, read_count, output ready);
endinterface

interface mfifo_rsp_if
   import mfifo_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [DATA_W-1:0]    out_byte;
   logic                 byte_valid;
   logic                 last;
   logic [STATUS_W-1:0]  status;
   logic [MSG_LEN_W-1:0] message_length;

   modport source (output valid, out_byte, byte_valid, last, status, message_length,
                   input ready);
   modport sink   (input valid, out_byte, byte_valid, last, status, message_length,
                   output ready);
endinterface

interface mfifo_csr_if
   import mfifo_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] max_message_bytes;

   modport source (output valid, max_message_bytes, input ready);
   modport sink   (input valid, max_message_bytes, output ready);
endinterface

/* rtl/mfifo_ctrl.sv */
// controller state machine: sequences write beats and read bursts
module mfifo_ctrl
   import mfifo_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_op,
   output logic           req_ready,
   input  dp_status_type  sts,
   output dp_cmd_type     cmd,
   output ctrl_state_type state
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               if (req_op == OP_WRITE) begin
                  cmd.write_byte = 1'b1;
               end else if (sts.queue_empty) begin
                  cmd.read_empty = 1'b1;
               end else if (sts.read_none) begin
                  cmd.read_none = 1'b1;
                  cmd.free_slot = 1'b1;
               end else begin
                  cmd.read_start = 1'b1;
                  state_in       = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_byte = 1'b1;
               if (sts.emit_last) begin
                  cmd.free_slot = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.fetch_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

/* rtl/mfifo_dp.sv */
// datapath: byte store, length table, slot pointers and result register
module mfifo_dp
   import mfifo_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        sts,
   input  logic [DATA_W-1:0]    req_data_byte,
   input  logic                 req_end_of_message,
   input  logic [RCOUNT_W-1:0]  req_read_count,
   input  logic                 csr_write,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [DATA_W-1:0]    rsp_out_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_last,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [MSG_LEN_W-1:0] rsp_message_length
);

   logic [CFG_W-1:0]   max_bytes_ff;
   logic [SLOT_W-1:0]  write_slot_ff;
   logic [SLOT_W-1:0]  read_slot_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [LEN_W-1:0]   bip_ff;
   logic               rejected_ff;

   logic [LEN_W-1:0]   len_table [FIFO_DEPTH];
   logic [DATA_W-1:0]  mem [MEM_DEPTH];
   logic [DATA_W-1:0]  mem_q_ff;
   logic [LEN_W-1:0]   rd_n_ff;
   logic [LEN_W-1:0]   rd_idx_ff;

   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    out_byte_ff;
   logic                 byte_valid_ff;
   logic                 last_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [MSG_LEN_W-1:0] msg_len_ff;

   logic [LEN_W-1:0]   lim;
   logic               rej_now;
   logic               keep;
   logic [LEN_W-1:0]   bip_plus;
   logic [LEN_W-1:0]   commit_len;
   logic [MEM_AW-1:0]  wr_addr;
   logic [LEN_W-1:0]   stored_len;
   logic [LEN_W-1:0]   rd_n_calc;
   logic [LEN_W-1:0]   rd_idx_in;
   logic               rd_en;
   logic [MEM_AW-1:0]  rd_addr;
   logic               out_free;
   logic               load_out;
   logic               commit;
   logic [SLOT_W-1:0]  write_slot_next;
   logic [SLOT_W-1:0]  read_slot_next;

   // effective limit: zero acts as one, clamp to slot size
   always_comb begin
      if (max_bytes_ff == '0) begin
         lim = LEN_W'(1);
      end else if (32'(max_bytes_ff) > ELEM_BYTES) begin
         lim = LEN_W'(ELEM_BYTES);
      end else begin
         lim = LEN_W'(max_bytes_ff);
      end
   end

   assign rej_now    = rejected_ff ||
                       ((bip_ff == '0) && (count_ff >= COUNT_W'(FIFO_DEPTH)));
   assign keep       = bip_ff < lim;
   assign bip_plus   = keep ? bip_ff + LEN_W'(1) : bip_ff;
   assign commit_len = (bip_plus < lim) ? bip_plus : lim;
   assign commit     = cmd.write_byte && !rej_now && req_end_of_message;
   assign wr_addr    = MEM_AW'(write_slot_ff) * MEM_AW'(ELEM_BYTES) + MEM_AW'(bip_ff);

   assign write_slot_next = (32'(write_slot_ff) + 1 >= FIFO_DEPTH) ? '0
                                                                   : write_slot_ff + 1'b1;
   assign read_slot_next  = (32'(read_slot_ff) + 1 >= FIFO_DEPTH) ? '0
                                                                  : read_slot_ff + 1'b1;

   // bytes a read returns
   assign stored_len = len_table[read_slot_ff];
   always_comb begin
      if (req_read_count < RCOUNT_W'(stored_len)) begin
         rd_n_calc = LEN_W'(req_read_count);
      end else begin
         rd_n_calc = stored_len;
      end
      if (32'(rd_n_calc) > ELEM_BYTES) begin
         rd_n_calc = LEN_W'(ELEM_BYTES);
      end
   end

   assign rd_idx_in = cmd.read_start ? '0 : rd_idx_ff + LEN_W'(1);
   assign rd_en     = cmd.read_start || cmd.fetch_next;
   assign rd_addr   = MEM_AW'(read_slot_ff) * MEM_AW'(ELEM_BYTES) + MEM_AW'(rd_idx_in);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_out = (cmd.write_byte && req_end_of_message) || cmd.read_empty ||
                     cmd.read_none || cmd.emit_byte;

   assign sts.queue_empty = (count_ff == '0);
   assign sts.read_none   = (rd_n_calc == '0);
   assign sts.emit_last   = ((rd_idx_ff + LEN_W'(1)) == rd_n_ff);
   assign sts.out_free    = out_free;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff  <= MAX_BYTES_RESET;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         count_ff      <= '0;
         bip_ff        <= '0;
         rejected_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            max_bytes_ff <= csr_data;
         end
         if (cmd.write_byte) begin
            if (rej_now) begin
               rejected_ff <= !req_end_of_message;
            end else if (req_end_of_message) begin
               write_slot_ff <= write_slot_next;
               count_ff      <= count_ff + COUNT_W'(1);
               bip_ff        <= '0;
            end else begin
               bip_ff <= bip_plus;
            end
         end
         if (cmd.free_slot) begin
            read_slot_ff <= read_slot_next;
            count_ff     <= count_ff - COUNT_W'(1);
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // byte store with registered read
   always_ff @(posedge clock) begin
      if (cmd.write_byte && !rej_now && keep) begin
         mem[wr_addr] <= req_data_byte;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // length table and read burst bookkeeping
   always_ff @(posedge clock) begin
      if (commit) begin
         len_table[write_slot_ff] <= commit_len;
      end
      if (cmd.read_start) begin
         rd_n_ff <= rd_n_calc;
      end
      if (rd_en) begin
         rd_idx_ff <= rd_idx_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_byte_ff   <= '0;
         byte_valid_ff <= 1'b0;
         last_ff       <= 1'b1;
         status_ff     <= STATUS_OK;
         msg_len_ff    <= '0;
         if (cmd.write_byte) begin
            if (rej_now) begin
               status_ff <= STATUS_FULL;
            end else begin
               msg_len_ff <= MSG_LEN_W'(commit_len);
            end
         end else if (cmd.read_empty) begin
            status_ff <= STATUS_EMPTY;
         end else if (cmd.emit_byte) begin
            out_byte_ff   <= mem_q_ff;
            byte_valid_ff <= 1'b1;
            last_ff       <= sts.emit_last;
            msg_len_ff    <= MSG_LEN_W'(rd_n_ff);
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_byte_valid     = byte_valid_ff;
   assign rsp_last           = last_ff;
   assign rsp_status         = status_ff;
   assign rsp_message_length = msg_len_ff;

endmodule

/* rtl/message_fifo_with_truncation_unit.sv */
// top level of the length-prefixed message fifo with truncation
//
//  channel   dir   beat contents
//  --------  ----  ------------------------------------------------------
//  req_chan  in    op, data_byte, end_of_message, read_count
//  rsp_chan  out   out_byte, byte_valid, last, status, message_length
//  csr_chan  in    max_message_bytes (always ready)
//
// a write beat is taken whenever idle and the result register is free; a result comes only on its closing beat
// a read of n bytes: accept in idle, the fetch state, then one byte per cycle while
//   rsp_chan does not stall, the fetch state set by the one registered read port
//   of the byte store; an empty or zero-byte read answers straight from idle
// reset clears pointers and counts and sets the limit register to 32; the
//   byte store and length table are not cleared, so there is no clearing pass
// req_chan.ready drops while a read burst drains or a result is held;
//   a stall on rsp_chan freezes the burst with the fetched byte kept
module message_fifo_with_truncation_unit
   import mfifo_pkg::*;
(
   input logic         clock,
   input logic         reset,
   mfifo_req_if.sink   req_chan,
   mfifo_rsp_if.source rsp_chan,
   mfifo_csr_if.sink   csr_chan
);

`include "message_fifo_with_truncation_unit_assert.svh"

   dp_cmd_type     cmd;
   dp_status_type  sts;
   ctrl_state_type state;

   // limit register write is never refused
   assign csr_chan.ready = 1'b1;

   // sequencing: write beats, read bursts, output register handoff
   mfifo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd),
      .state     (state)
   );

   // storage, pointers and the result register
   mfifo_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_data_byte      (req_chan.data_byte),
      .req_end_of_message (req_chan.end_of_message),
      .req_read_count     (req_chan.read_count),
      .csr_write          (csr_chan.valid),
      .csr_data           (csr_chan.max_message_bytes),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_out_byte       (rsp_chan.out_byte),
      .rsp_byte_valid     (rsp_chan.byte_valid),
      .rsp_last           (rsp_chan.last),
      .rsp_status         (rsp_chan.status),
      .rsp_message_length (rsp_chan.message_length)
   );

   // data beats only come from a successful read
   `MFIFO_ASSERT_IMPL(a_data_beat_ok, clock, reset, rsp_chan.valid && rsp_chan.byte_valid, rsp_chan.status == STATUS_OK)
   // beats without data are always single, closing beats
   `MFIFO_ASSERT_IMPL(a_nodata_last, clock, reset, rsp_chan.valid && !rsp_chan.byte_valid, rsp_chan.last)
   // a started burst holds off new requests
   `MFIFO_ASSERT_NEXT(a_burst_blocks, clock, reset, cmd.read_start, !req_chan.ready && state == ST_FETCH)

endmodule
